// File: rtl/core/area_centroid_and_bboxes_top_macros.svh
// Assertion macros shared by the RTL of the centroid and box block.
`ifndef AREA_CENTROID_AND_BBOXES_TOP_MACROS_SVH
`define AREA_CENTROID_AND_BBOXES_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ACB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ACB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/core/acb_pkg.sv
// Package with widths, constants and types of the centroid and box block.
package acb_pkg;
    localparam int CoordBits    = 16;
    localparam int MaxTriangles = 4096;
    localparam int CountBits    = $clog2(MaxTriangles + 1);
    localparam int DaBits       = 2 * CoordBits + 2;
    localparam int AreaBits     = 47;
    localparam int SumBits      = 64;
    localparam int DenBits      = AreaBits + 2;
    localparam int QBits        = 66;
    localparam int QueueDepth   = 4;
    localparam int QPtrBits     = $clog2(QueueDepth);

    localparam logic signed [CoordBits-1:0] CoordHi = {1'b0, {(CoordBits-1){1'b1}}};
    localparam logic signed [CoordBits-1:0] CoordLo = {1'b1, {(CoordBits-1){1'b0}}};

    typedef enum logic {
        KIND_BOX      = 1'b0,
        KIND_CENTROID = 1'b1
    } t_kind;

    // One triangle as the front stage hands it to the back stage.
    typedef struct packed {
        logic [DaBits-1:0]        da;
        logic signed [CoordBits+1:0] sx;
        logic signed [CoordBits+1:0] sy;
        logic                     counted;
        logic                     elem_end;
        logic                     set_end;
        logic signed [CoordBits-1:0] bmin_x;
        logic signed [CoordBits-1:0] bmin_y;
        logic signed [CoordBits-1:0] bmax_x;
        logic signed [CoordBits-1:0] bmax_y;
    } t_tri;

    typedef struct packed {
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] bx;
        logic [15:0] by;
        logic [15:0] cx;
        logic [15:0] cy;
        logic        elem_end;
        logic        set_end;
    } t_in_word;

    typedef struct packed {
        logic        kind;
        logic [15:0] min_x;
        logic [15:0] min_y;
        logic [15:0] max_x;
        logic [15:0] max_y;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic        degenerate;
        logic        overflow;
        logic        last;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_MUL,
        ST_BOX,
        ST_DIV,
        ST_CENTER
    } t_back_state;
endpackage

// File: rtl/core/acb_if.sv
// Valid/ready channel interfaces for the input and output words.
interface acb_in_if;
    import acb_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface acb_out_if;
    import acb_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/acb_front.sv
// Front stage: cross product, vertex sums, element box and triangle count.
module acb_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    acb_in_if.sink                i_in,
    output logic                  o_push,
    output acb_pkg::t_tri         o_tri,
    input  logic                  i_full
);
    import acb_pkg::*;

    logic signed [CoordBits-1:0] x0, y0, x1, y1, x2, y2;
    logic signed [CoordBits:0]   e1x, e1y, e2x, e2y;
    logic signed [2*CoordBits+2:0] cr;
    logic signed [CoordBits-1:0] r_min_x, r_min_y, r_max_x, r_max_y;
    logic signed [CoordBits-1:0] n_min_x, n_min_y, n_max_x, n_max_y;
    logic [CountBits-1:0] r_count;
    logic counted, acc, elem;

    assign x0 = i_in.data.ax[CoordBits-1:0];
    assign y0 = i_in.data.ay[CoordBits-1:0];
    assign x1 = i_in.data.bx[CoordBits-1:0];
    assign y1 = i_in.data.by[CoordBits-1:0];
    assign x2 = i_in.data.cx[CoordBits-1:0];
    assign y2 = i_in.data.cy[CoordBits-1:0];

    assign i_in.ready = !i_full;
    assign acc = i_in.valid && !i_full;
    assign elem = i_in.data.elem_end || i_in.data.set_end;
    assign counted = (r_count != CountBits'(MaxTriangles));

    always_comb begin
        e1x = (CoordBits+1)'(x1) - (CoordBits+1)'(x0);
        e1y = (CoordBits+1)'(y1) - (CoordBits+1)'(y0);
        e2x = (CoordBits+1)'(x2) - (CoordBits+1)'(x0);
        e2y = (CoordBits+1)'(y2) - (CoordBits+1)'(y0);
        cr = (2*CoordBits+3)'(e1x * e2y) - (2*CoordBits+3)'(e2x * e1y);
        n_min_x = r_min_x; n_min_y = r_min_y; n_max_x = r_max_x; n_max_y = r_max_y;
        if (x0 < n_min_x) n_min_x = x0;
        if (x1 < n_min_x) n_min_x = x1;
        if (x2 < n_min_x) n_min_x = x2;
        if (y0 < n_min_y) n_min_y = y0;
        if (y1 < n_min_y) n_min_y = y1;
        if (y2 < n_min_y) n_min_y = y2;
        if (x0 > n_max_x) n_max_x = x0;
        if (x1 > n_max_x) n_max_x = x1;
        if (x2 > n_max_x) n_max_x = x2;
        if (y0 > n_max_y) n_max_y = y0;
        if (y1 > n_max_y) n_max_y = y1;
        if (y2 > n_max_y) n_max_y = y2;
        o_tri.da = DaBits'(cr < 0 ? -cr : cr);
        o_tri.sx = (CoordBits+2)'(x0) + (CoordBits+2)'(x1) + (CoordBits+2)'(x2);
        o_tri.sy = (CoordBits+2)'(y0) + (CoordBits+2)'(y1) + (CoordBits+2)'(y2);
        o_tri.counted = counted;
        o_tri.elem_end = elem;
        o_tri.set_end = i_in.data.set_end;
        o_tri.bmin_x = n_min_x;
        o_tri.bmin_y = n_min_y;
        o_tri.bmax_x = n_max_x;
        o_tri.bmax_y = n_max_y;
    end

    assign o_push = acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= CoordHi; r_min_y <= CoordHi;
            r_max_x <= CoordLo; r_max_y <= CoordLo;
            r_count <= '0;
        end else if (acc) begin
            if (elem) begin
                r_min_x <= CoordHi; r_min_y <= CoordHi;
                r_max_x <= CoordLo; r_max_y <= CoordLo;
            end else begin
                r_min_x <= n_min_x; r_min_y <= n_min_y;
                r_max_x <= n_max_x; r_max_y <= n_max_y;
            end
            if (i_in.data.set_end) r_count <= '0;
            else if (counted) r_count <= r_count + 1'b1;
        end
    end

    `include "area_centroid_and_bboxes_top_macros.svh"
    `ACB_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CountBits'(MaxTriangles))
    `ACB_ASSERT_NEXT(a_box_reset, i_clk, i_rst_n, acc && elem, r_min_x == CoordHi && r_max_x == CoordLo)
    `ACB_ASSERT_IMP(a_push_room, i_clk, i_rst_n, o_push, !i_full)
endmodule

// File: rtl/core/acb_queue.sv
// Short first-in first-out queue between the front and back stages.
module acb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  acb_pkg::t_tri i_tri,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output acb_pkg::t_tri o_tri
);
    import acb_pkg::*;

    t_tri r_mem [QueueDepth];
    logic [QPtrBits-1:0] r_wp, r_rp;
    logic [QPtrBits:0]   r_cnt;

    assign o_full = (r_cnt == (QPtrBits+1)'(QueueDepth));
    assign o_empty = (r_cnt == '0);
    assign o_tri = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_tri;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPtrBits+1)'(i_push) - (QPtrBits+1)'(i_pop);
        end
    end

    `include "area_centroid_and_bboxes_top_macros.svh"
    `ACB_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty)
    `ACB_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `ACB_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= (QPtrBits+1)'(QueueDepth))
endmodule

// File: rtl/core/acb_back.sv
// Back stage: area and weighted sums, result words and the centroid divider.
module acb_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  acb_pkg::t_tri i_tri,
    output logic          o_pop,
    acb_out_if.source     o_out
);
    import acb_pkg::*;

    t_back_state r_st, n_st;
    t_tri        r_t;
    logic [AreaBits-1:0]      r_area;
    logic signed [SumBits-1:0] r_wx, r_wy;
    logic signed [SumBits-1:0] r_px, r_py;
    logic                     r_ovf;
    // Divider state: magnitudes and a restoring divider per axis, sharing one denominator and step count.
    logic [DenBits-1:0]  r_den;
    logic [QBits-1:0]    r_nx, r_ny;
    logic [DenBits:0]    r_remx, r_remy;
    logic [6:0]          r_step;
    logic                r_negx, r_negy;
    logic                r_degen;
    logic                r_ov, n_ov;
    t_out_word           r_ow, n_ow;

    logic [DenBits:0] tx, ty;
    logic [SumBits-1:0] magx, magy;
    logic [QBits-1:0] qx, qy;

    function automatic logic [15:0] sat(input logic [QBits-1:0] q, input logic neg);
        logic [15:0] r;
        if (neg) begin
            if (q > QBits'(-int'(CoordLo))) r = 16'(CoordLo);
            else r = 16'(-q);
        end else begin
            if (q > QBits'(CoordHi)) r = 16'(CoordHi);
            else r = q[15:0];
        end
        return r;
    endfunction

    assign o_out.valid = r_ov;
    assign o_out.data = r_ow;

    always_comb begin
        magx = r_wx[SumBits-1] ? SumBits'(-r_wx) : r_wx;
        magy = r_wy[SumBits-1] ? SumBits'(-r_wy) : r_wy;
        tx = {r_remx[DenBits-1:0], r_nx[QBits-1]};
        ty = {r_remy[DenBits-1:0], r_ny[QBits-1]};
        qx = r_nx; qy = r_ny;
        n_st = r_st;
        o_pop = 1'b0;
        n_ov = r_ov && !o_out.ready;
        n_ow = r_ow;
        unique case (r_st)
            ST_ACCUM: if (!i_empty) begin
                o_pop = 1'b1;
                n_st = ST_MUL;
            end
            ST_MUL: n_st = r_t.elem_end ? ST_BOX : ST_ACCUM;
            ST_BOX: if (!r_ov || o_out.ready) begin
                n_st = r_t.set_end ? ST_DIV : ST_ACCUM;
                n_ov = 1'b1;
                n_ow = '0;
                n_ow.kind = KIND_BOX;
                n_ow.min_x = r_t.bmin_x; n_ow.min_y = r_t.bmin_y;
                n_ow.max_x = r_t.bmax_x; n_ow.max_y = r_t.bmax_y;
                n_ow.last = !r_t.set_end;
            end
            ST_DIV: if (r_step == 7'(QBits)) n_st = ST_CENTER;
            ST_CENTER: if (!r_ov || o_out.ready) begin
                n_st = ST_ACCUM;
                n_ov = 1'b1;
                n_ow = '0;
                n_ow.kind = KIND_CENTROID;
                n_ow.center_x = r_degen ? 16'd0 : sat(qx, r_negx);
                n_ow.center_y = r_degen ? 16'd0 : sat(qy, r_negy);
                n_ow.degenerate = r_degen;
                n_ow.overflow = r_ovf;
                n_ow.last = 1'b1;
            end
            default: n_st = ST_ACCUM;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= ST_ACCUM;
        else r_st <= n_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area <= '0; r_wx <= '0; r_wy <= '0; r_ovf <= 1'b0; r_ov <= 1'b0;
            r_ow <= '0;
        end else begin
            r_ov <= n_ov;
            r_ow <= n_ow;
            case (r_st)
                ST_ACCUM: if (o_pop) begin
                    r_t <= i_tri;
                    r_px <= SumBits'(signed'({1'b0, i_tri.da}) * i_tri.sx);
                    r_py <= SumBits'(signed'({1'b0, i_tri.da}) * i_tri.sy);
                end
                ST_MUL: begin
                    if (r_t.counted) begin
                        r_area <= r_area + AreaBits'(r_t.da);
                        r_wx <= r_wx + r_px;
                        r_wy <= r_wy + r_py;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
                ST_BOX: if (!r_ov || o_out.ready) begin
                    // Numerator 2|w|+den, denominator 2*den for round half away.
                    r_den <= {r_area, 1'b0} + {r_area, 2'b0};
                    r_nx <= QBits'({magx, 1'b0}) + QBits'({r_area, 1'b0} + r_area);
                    r_ny <= QBits'({magy, 1'b0}) + QBits'({r_area, 1'b0} + r_area);
                    r_negx <= r_wx[SumBits-1]; r_negy <= r_wy[SumBits-1];
                    r_degen <= (r_area == '0);
                    r_remx <= '0; r_remy <= '0; r_step <= '0;
                end
                ST_DIV: if (r_step != 7'(QBits)) begin
                    r_step <= r_step + 1'b1;
                    if (tx >= {1'b0, r_den}) begin
                        r_remx <= tx - {1'b0, r_den}; r_nx <= {r_nx[QBits-2:0], 1'b1};
                    end else begin
                        r_remx <= tx; r_nx <= {r_nx[QBits-2:0], 1'b0};
                    end
                    if (ty >= {1'b0, r_den}) begin
                        r_remy <= ty - {1'b0, r_den}; r_ny <= {r_ny[QBits-2:0], 1'b1};
                    end else begin
                        r_remy <= ty; r_ny <= {r_ny[QBits-2:0], 1'b0};
                    end
                end
                ST_CENTER: if (!r_ov || o_out.ready) begin
                    r_area <= '0; r_wx <= '0; r_wy <= '0; r_ovf <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    `include "area_centroid_and_bboxes_top_macros.svh"
    `ACB_ASSERT_IMP(a_pop_idle, i_clk, i_rst_n, o_pop, r_st == ST_ACCUM)
    `ACB_ASSERT_IMP(a_center_last, i_clk, i_rst_n, r_ov && r_ow.kind == KIND_CENTROID, r_ow.last)
    `ACB_ASSERT_NEXT(a_div_done, i_clk, i_rst_n, r_st == ST_CENTER, r_step == 7'(QBits))
endmodule

// File: rtl/core/area_centroid_and_bboxes_top.sv
// Top level of the area weighted centroid and element box block.
// Triangles are accepted at up to one per cycle into a four-entry queue while
// the queue has room; the back stage takes each triangle through a multiply
// and then an accumulate, emits a box word at each element end, and at a set
// end runs a restoring divider per axis, sharing one denominator, for the centroid word.
module area_centroid_and_bboxes_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    acb_in_if.sink    i_in,
    acb_out_if.source o_out
);
    import acb_pkg::*;

    logic push, full, pop, empty;
    t_tri tri_in, tri_out;

    acb_front u_front (.i_clk, .i_rst_n, .i_in(i_in), .o_push(push), .o_tri(tri_in),
                       .i_full(full));
    acb_queue u_queue (.i_clk, .i_rst_n, .i_push(push), .i_tri(tri_in), .o_full(full),
                       .i_pop(pop), .o_empty(empty), .o_tri(tri_out));
    acb_back u_back (.i_clk, .i_rst_n, .i_empty(empty), .i_tri(tri_out), .o_pop(pop),
                     .o_out(o_out));
endmodule
